[src/sps_pkg.sv]
package sps_pkg;

  localparam int unsigned MaxResults = 54;
  localparam int unsigned ResCntW = 6;
  localparam int unsigned DivSteps = 32;

  localparam logic [1:0] REQ_CLEAR  = 2'd0;
  localparam logic [1:0] REQ_APPEND = 2'd1;
  localparam logic [1:0] REQ_SIEVE  = 2'd2;

  localparam logic REG_LIMIT = 1'b0;
  localparam logic REG_CLEN  = 1'b1;

  localparam logic [31:0] LimitReset = 32'd1000000;
  localparam logic [8:0]  ClenReset  = 9'd150;

  typedef enum logic [12:0] {
    ST_IDLE   = 13'b0000000000001,
    ST_SETUP  = 13'b0000000000010,
    ST_CALC   = 13'b0000000000100,
    ST_EVAL   = 13'b0000000001000,
    ST_FILL   = 13'b0000000010000,
    ST_TREAD  = 13'b0000000100000,
    ST_TWAIT  = 13'b0000001000000,
    ST_TCHK   = 13'b0000010000000,
    ST_DIV    = 13'b0000100000000,
    ST_MSTART = 13'b0001000000000,
    ST_MARK   = 13'b0010000000000,
    ST_SRD    = 13'b0100000000000,
    ST_SCK    = 13'b1000000000000
  } state_e;

  typedef struct packed {
    logic in_ready;
    logic mul;
    logic calc;
    logic eval;
    logic fill;
    logic t_rd;
    logic t_inc;
    logic sq;
    logic div_start;
    logic div_step;
    logic mstart;
    logic mark;
    logic s_rd;
    logic s_inc;
    logic take;
    logic push_mid;
    logic push_fin;
  } cmd_t;

  typedef struct packed {
    logic in_valid;
    logic req_sieve;
    logic empty;
    logic fill_last;
    logic t_end;
    logic p_small;
    logic sq_big;
    logic div_last;
    logic mark_more;
    logic hit;
    logic pend_v;
    logic out_free;
    logic s_last;
  } sts_t;

endpackage

[src/sps_if.sv]
interface sps_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  req_type;
  logic [15:0] base_prime;
  logic [31:0] chunk_index;
  modport source (output valid, req_type, base_prime, chunk_index, input ready);
  modport sink (input valid, req_type, base_prime, chunk_index, output ready);
endinterface

interface sps_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] prime_value;
  logic        prime_valid;
  logic        last;
  modport source (output valid, prime_value, prime_valid, last, input ready);
  modport sink (input valid, prime_value, prime_valid, last, output ready);
endinterface

[src/sps_ram.sv]
module sps_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;
endmodule

[src/sps_ctrl.sv]
module sps_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  sps_pkg::sts_t sts_i,
  output sps_pkg::cmd_t cmd_o
);
  import sps_pkg::*;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        cmd_o.in_ready = 1'b1;
        if (sts_i.in_valid && sts_i.req_sieve) begin
          state_d = ST_SETUP;
        end
      end
      ST_SETUP: begin
        cmd_o.mul = 1'b1;
        state_d = ST_CALC;
      end
      ST_CALC: begin
        cmd_o.calc = 1'b1;
        state_d = ST_EVAL;
      end
      ST_EVAL: begin
        cmd_o.eval = 1'b1;
        state_d = sts_i.empty ? ST_SCK : ST_FILL;
        if (sts_i.empty) begin
          state_d = ST_SRD;
        end
      end
      ST_FILL: begin
        cmd_o.fill = 1'b1;
        if (sts_i.fill_last) begin
          state_d = ST_TREAD;
        end
      end
      ST_TREAD: begin
        if (sts_i.t_end) begin
          state_d = ST_SRD;
        end else begin
          cmd_o.t_rd = 1'b1;
          state_d = ST_TWAIT;
        end
      end
      ST_TWAIT: begin
        cmd_o.sq = 1'b1;
        state_d = ST_TCHK;
      end
      ST_TCHK: begin
        if (sts_i.p_small) begin
          cmd_o.t_inc = 1'b1;
          state_d = ST_TREAD;
        end else if (sts_i.sq_big) begin
          state_d = ST_SRD;
        end else begin
          cmd_o.div_start = 1'b1;
          state_d = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_last) begin
          state_d = ST_MSTART;
        end
      end
      ST_MSTART: begin
        cmd_o.mstart = 1'b1;
        state_d = ST_MARK;
      end
      ST_MARK: begin
        if (sts_i.mark_more) begin
          cmd_o.mark = 1'b1;
        end else begin
          cmd_o.t_inc = 1'b1;
          state_d = ST_TREAD;
        end
      end
      ST_SRD: begin
        if (sts_i.empty) begin
          if (sts_i.out_free) begin
            cmd_o.push_fin = 1'b1;
            state_d = ST_IDLE;
          end
        end else begin
          cmd_o.s_rd = 1'b1;
          state_d = ST_SCK;
        end
      end
      ST_SCK: begin
        if (!(sts_i.hit && sts_i.pend_v && !sts_i.out_free)) begin
          if (sts_i.hit) begin
            cmd_o.take = 1'b1;
            cmd_o.push_mid = sts_i.pend_v;
          end
          if (sts_i.s_last) begin
            state_d = ST_SRD;
            cmd_o.eval = 1'b0;
            cmd_o.s_inc = 1'b1;
          end else begin
            cmd_o.s_inc = 1'b1;
            state_d = ST_SRD;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end
endmodule

[src/sps_dp.sv]
module sps_dp #(
  parameter int unsigned MaxChunk = 256,
  parameter int unsigned MaxBasePrimes = 8192
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic [31:0]   limit_i,
  input  logic [8:0]    clen_i,
  input  sps_pkg::cmd_t cmd_i,
  output sps_pkg::sts_t sts_o,
  sps_in_if.sink        in_s,
  sps_out_if.source     out_s
);
  import sps_pkg::*;

  localparam int unsigned AW  = (MaxChunk > 1) ? $clog2(MaxChunk) : 1;
  localparam int unsigned BAW = $clog2(MaxBasePrimes);
  localparam int unsigned BCW = $clog2(MaxBasePrimes + 1);
  localparam int unsigned IW  = 18;
  localparam logic [12:0] MaxChunkV = 13'(MaxChunk);

  logic [31:0]      chunk_q;
  logic [8:0]       len_q;
  logic [40:0]      prod_q;
  logic [41:0]      lo_q;
  logic [31:0]      hi_q;
  logic [AW-1:0]    nm1_q;
  logic             empty_q;
  logic [AW-1:0]    i_q;
  logic [AW-1:0]    s_q;
  logic [BCW-1:0]   t_q;
  logic [BCW-1:0]   bcnt_q;
  logic [15:0]      p_q;
  logic [31:0]      sq_q;
  logic [16:0]      rem_q;
  logic [31:0]      dq_q;
  logic [5:0]       dcnt_q;
  logic [IW-1:0]    idx_q;
  logic             pend_v_q;
  logic [31:0]      pend_q;
  logic [ResCntW-1:0] rcnt_q;
  logic             out_v_q;
  logic [31:0]      oval_q;
  logic             opv_q;
  logic             olast_q;

  logic             acc;
  logic [15:0]      bp_rd;
  logic             mk_rd;
  logic             mk_we;
  logic [AW-1:0]    mk_waddr;
  logic             mk_wdata;
  logic             bp_we;
  logic [41:0]      hi_raw;
  logic [16:0]      r2;
  logic [16:0]      r2s;
  logic [32:0]      idx_w;
  logic             out_free;
  logic [8:0]       len_sat;

  assign acc = in_s.valid && cmd_i.in_ready;
  assign in_s.ready = cmd_i.in_ready;
  assign bp_we = acc && (in_s.req_type == REQ_APPEND) && (bcnt_q < BCW'(MaxBasePrimes));
  assign len_sat = ({4'b0, clen_i} > MaxChunkV) ? 9'(MaxChunk) : clen_i;

  sps_ram #(.Width(16), .Depth(MaxBasePrimes)) u_bp_ram (
    .clk_i   (clk_i),
    .we_i    (bp_we),
    .waddr_i (bcnt_q[BAW-1:0]),
    .wdata_i (in_s.base_prime),
    .re_i    (cmd_i.t_rd),
    .raddr_i (t_q[BAW-1:0]),
    .rdata_o (bp_rd)
  );

  assign mk_we    = cmd_i.fill || cmd_i.mark;
  assign mk_waddr = cmd_i.fill ? i_q : idx_q[AW-1:0];
  assign mk_wdata = cmd_i.fill && !((i_q == '0) && (lo_q == 42'd1));

  sps_ram #(.Width(1), .Depth(MaxChunk)) u_mk_ram (
    .clk_i   (clk_i),
    .we_i    (mk_we),
    .waddr_i (mk_waddr),
    .wdata_i (mk_wdata),
    .re_i    (cmd_i.s_rd),
    .raddr_i (s_q),
    .rdata_o (mk_rd)
  );

  assign hi_raw = {1'b0, prod_q} + {33'b0, len_q};
  assign r2     = {rem_q[15:0], dq_q[31]};
  assign r2s    = (r2 >= {1'b0, p_q}) ? (r2 - {1'b0, p_q}) : r2;
  assign idx_w  = ({10'b0, sq_q} >= lo_q) ? ({1'b0, sq_q} - lo_q[32:0])
                : ((rem_q == '0) ? 33'd0 : ({17'b0, p_q} - {16'b0, rem_q}));
  assign out_free = !out_v_q || out_s.ready;

  always_ff @(posedge clk_i) begin
    if (acc) begin
      chunk_q <= in_s.chunk_index;
      len_q   <= len_sat;
    end
    if (cmd_i.mul) begin
      prod_q <= chunk_q * len_q;
    end
    if (cmd_i.calc) begin
      lo_q <= {1'b0, prod_q} + 42'd1;
      hi_q <= (hi_raw > {10'b0, limit_i}) ? limit_i : hi_raw[31:0];
    end
    if (cmd_i.eval) begin
      nm1_q <= AW'(hi_q - lo_q[31:0]);
    end
    if (cmd_i.sq) begin
      p_q  <= bp_rd;
      sq_q <= bp_rd * bp_rd;
    end
    if (cmd_i.div_start) begin
      rem_q <= '0;
      dq_q  <= lo_q[31:0];
    end else if (cmd_i.div_step) begin
      rem_q <= r2s;
      dq_q  <= {dq_q[30:0], 1'b0};
    end
    if (cmd_i.mstart) begin
      idx_q <= IW'(idx_w);
    end else if (cmd_i.mark) begin
      idx_q <= idx_q + IW'(p_q);
    end
    if (cmd_i.take) begin
      pend_q <= lo_q[31:0] + 32'(s_q);
    end
    if (cmd_i.push_mid) begin
      oval_q  <= pend_q;
      opv_q   <= 1'b1;
      olast_q <= 1'b0;
    end else if (cmd_i.push_fin) begin
      oval_q  <= pend_v_q ? pend_q : 32'd0;
      opv_q   <= pend_v_q;
      olast_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bcnt_q   <= '0;
      empty_q  <= 1'b0;
      i_q      <= '0;
      s_q      <= '0;
      t_q      <= '0;
      dcnt_q   <= '0;
      pend_v_q <= 1'b0;
      rcnt_q   <= '0;
      out_v_q  <= 1'b0;
    end else begin
      if (acc && (in_s.req_type == REQ_CLEAR)) begin
        bcnt_q <= '0;
      end else if (bp_we) begin
        bcnt_q <= bcnt_q + 1'b1;
      end
      if (acc) begin
        i_q      <= '0;
        s_q      <= '0;
        t_q      <= '0;
        pend_v_q <= 1'b0;
        rcnt_q   <= '0;
        empty_q  <= 1'b0;
      end
      if (cmd_i.eval) begin
        empty_q <= (len_q == '0) || (lo_q > {10'b0, hi_q});
      end
      if (cmd_i.fill) begin
        i_q <= i_q + 1'b1;
      end
      if (cmd_i.t_inc) begin
        t_q <= t_q + 1'b1;
      end
      if (cmd_i.div_start) begin
        dcnt_q <= 6'(DivSteps);
      end else if (cmd_i.div_step) begin
        dcnt_q <= dcnt_q - 1'b1;
      end
      if (cmd_i.take) begin
        pend_v_q <= 1'b1;
        rcnt_q   <= rcnt_q + 1'b1;
      end
      if (cmd_i.s_inc) begin
        if (s_q == nm1_q) begin
          empty_q <= 1'b1;
        end else begin
          s_q <= s_q + 1'b1;
        end
      end
      if (cmd_i.push_mid || cmd_i.push_fin) begin
        out_v_q <= 1'b1;
      end else if (out_s.ready) begin
        out_v_q <= 1'b0;
      end
    end
  end

  always_comb begin
    sts_o           = '0;
    sts_o.in_valid  = in_s.valid;
    sts_o.req_sieve = (in_s.req_type == REQ_SIEVE);
    sts_o.empty     = cmd_i.eval ? ((len_q == '0) || (lo_q > {10'b0, hi_q})) : empty_q;
    sts_o.fill_last = (i_q == nm1_q);
    sts_o.t_end     = (t_q >= bcnt_q);
    sts_o.p_small   = (p_q < 16'd2);
    sts_o.sq_big    = (sq_q > hi_q);
    sts_o.div_last  = (dcnt_q == 6'd1);
    sts_o.mark_more = (idx_q <= IW'(nm1_q));
    sts_o.hit       = mk_rd && (rcnt_q < ResCntW'(MaxResults));
    sts_o.pend_v    = pend_v_q;
    sts_o.out_free  = out_free;
    sts_o.s_last    = (s_q == nm1_q);
  end

  assign out_s.valid       = out_v_q;
  assign out_s.prime_value = oval_q;
  assign out_s.prime_valid = opv_q;
  assign out_s.last        = olast_q;
endmodule

[src/segmented_prime_sieve.sv]
// Segmented prime sieve. Beats on the input channel either clear the base
// prime table, append one base prime, or request a sieve of one chunk.
// A sieve beat covers the numbers chunk*len+1 through the smaller of
// (chunk+1)*len and limit_n and returns its surviving primes, at most 54,
// in ascending order on the output channel, the final beat flagged by last.
// An empty chunk returns one beat with prime_valid low. A chunk passes
// through setup, a fill of the mark memory, then for each base prime a table
// read, a square, a remainder unit that takes one bit per cycle and the
// crossing of its multiples, then a scan of every number and a close, so
// the work grows with the count of base primes whose square does not exceed
// the chunk's upper end. New input is taken only once the final result has
// been placed in the output register. When the receiver stalls, the scan
// waits and the output beat holds. Reset empties the base table and restores
// limit_n to 1000000 and chunk_len to 150. Registers are to be written through
// the APB port only while the block is idle; the block does not enforce this.
module segmented_prime_sieve #(
  parameter int unsigned MaxChunk = 256,
  parameter int unsigned MaxBasePrimes = 8192
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  sps_in_if.sink      in_s,
  sps_out_if.source   out_s,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import sps_pkg::*;

  logic [31:0] limit_q;
  logic [8:0]  clen_q;
  cmd_t        cmd;
  sts_t        sts;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_CLEN) ? {23'b0, clen_q} : limit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= LimitReset;
      clen_q  <= ClenReset;
    end else if (psel && penable && pwrite) begin
      if (paddr[2] == REG_LIMIT) begin
        limit_q <= pwdata;
      end else begin
        clen_q <= pwdata[8:0];
      end
    end
  end

  sps_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .sts_i  (sts),
    .cmd_o  (cmd)
  );

  sps_dp #(.MaxChunk(MaxChunk), .MaxBasePrimes(MaxBasePrimes)) u_dp (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .limit_i (limit_q),
    .clen_i  (clen_q),
    .cmd_i   (cmd),
    .sts_o   (sts),
    .in_s    (in_s),
    .out_s   (out_s)
  );
endmodule

[src/sps_checker.sv]
module sps_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [31:0] out_value_i,
  input logic        out_pvalid_i,
  input logic        out_last_i
);
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_value_i)
      && $stable(out_last_i) && $stable(out_pvalid_i))
    else $error("output beat changed while stalled");

  a_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_pvalid_i |-> out_last_i && (out_value_i == 32'd0))
    else $error("empty chunk beat malformed");

  a_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_pvalid_i |-> out_value_i > 32'd1)
    else $error("reported prime below two");
endmodule

bind segmented_prime_sieve sps_checker u_chk (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .out_valid_i  (out_s.valid),
  .out_ready_i  (out_s.ready),
  .out_value_i  (out_s.prime_value),
  .out_pvalid_i (out_s.prime_valid),
  .out_last_i   (out_s.last)
);

[dv/sieve_checker.sv]
module sieve_checker #(
  parameter int unsigned MaxChunk = 256,
  parameter int unsigned MaxBasePrimes = 8192
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  sps_in_if           in_w,
  sps_out_if          out_w,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  output int          fail_count_o,
  output int          pending_o
);
  import sps_pkg::*;

  typedef struct packed {
    logic [31:0] value;
    logic        has_prime;
    logic        last;
  } prime_beat_t;

  prime_beat_t  primes_due_q[$];
  logic [15:0]  base_tab[MaxBasePrimes];
  int unsigned  base_cnt;
  logic [31:0]  limit_r;
  logic [8:0]   clen_r;

  task automatic sieve_predict(input logic [31:0] chunk);
    longint unsigned len, lo, hi, n, p, sq, start, j;
    bit          marks[MaxChunk];
    prime_beat_t found_q[$];
    prime_beat_t b;
    len = clen_r;
    if (len > MaxChunk) len = MaxChunk;
    lo = longint'(chunk) * len + 1;
    hi = (longint'(chunk) + 1) * len;
    if (hi > limit_r) hi = limit_r;
    if (len == 0 || lo > hi) begin
      primes_due_q.push_back('{value: '0, has_prime: 1'b0, last: 1'b1});
      return;
    end
    n = hi - lo + 1;
    for (int i = 0; i < n; i++) marks[i] = 1'b1;
    if (lo == 1) marks[0] = 1'b0;
    for (int t = 0; t < base_cnt; t++) begin
      p = base_tab[t];
      if (p < 2) continue;
      sq = p * p;
      if (sq > hi) break;
      start = p * ((lo + p - 1) / p);
      if (start < sq) start = sq;
      for (j = start; j <= hi; j += p) marks[j - lo] = 1'b0;
    end
    for (int i = 0; i < n && found_q.size() < MaxResults; i++) begin
      if (marks[i]) found_q.push_back('{value: 32'(lo + i), has_prime: 1'b1, last: 1'b0});
    end
    if (found_q.size() == 0) begin
      primes_due_q.push_back('{value: '0, has_prime: 1'b0, last: 1'b1});
      return;
    end
    found_q[found_q.size() - 1].last = 1'b1;
    foreach (found_q[k]) primes_due_q.push_back(found_q[k]);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    prime_beat_t want;
    if (!rst_ni) begin
      primes_due_q.delete();
      base_cnt = 0;
      limit_r = LimitReset;
      clen_r = ClenReset;
      fail_count_o = 0;
      pending_o = 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        if (paddr[2] == REG_LIMIT) limit_r = pwdata;
        else clen_r = pwdata[8:0];
      end
      if (out_w.valid && out_w.ready) begin
        if (primes_due_q.size() == 0) begin
          $display("%0t: unexpected beat value=%0d valid=%0b last=%0b", $time,
                   out_w.prime_value, out_w.prime_valid, out_w.last);
          fail_count_o++;
        end else begin
          want = primes_due_q.pop_front();
          if (want.value !== out_w.prime_value || want.has_prime !== out_w.prime_valid ||
              want.last !== out_w.last) begin
            $display("%0t: mismatch expected value=%0d valid=%0b last=%0b, got %0d %0b %0b",
                     $time, want.value, want.has_prime, want.last,
                     out_w.prime_value, out_w.prime_valid, out_w.last);
            fail_count_o++;
          end
        end
      end
      if (in_w.valid && in_w.ready) begin
        case (in_w.req_type)
          REQ_CLEAR: base_cnt = 0;
          REQ_APPEND: begin
            if (base_cnt < MaxBasePrimes) begin
              base_tab[base_cnt] = in_w.base_prime;
              base_cnt++;
            end
          end
          REQ_SIEVE: sieve_predict(in_w.chunk_index);
          default: ;
        endcase
      end
      pending_o = primes_due_q.size();
    end
  end
endmodule

[dv/tb_top.sv]
module tb_top;
  import sps_pkg::*;

  localparam logic [1:0] REQ_BOGUS = 2'd3;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  int          fail_count;
  int          pending;
  int          snd_idle_pct = 0;
  int          rcv_stall_pct = 0;
  int          hold_cycles = 0;
  int unsigned seed_primes[$];

  sps_in_if  in_if ();
  sps_out_if out_if ();

  segmented_prime_sieve dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .in_s(in_if), .out_s(out_if),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  sieve_checker u_checker (
    .clk_i(clk_i), .rst_ni(rst_ni), .in_w(in_if), .out_w(out_if),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .pready(pready), .fail_count_o(fail_count), .pending_o(pending)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  initial begin
    #(12 * 40_000_000);
    $display("FAIL segmented_prime_sieve");
    $finish;
  end

  initial begin
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_cycles > 0) begin
        out_if.ready = 1'b0;
        hold_cycles--;
      end else begin
        out_if.ready = ($urandom_range(99) >= rcv_stall_pct);
      end
    end
  end

  task automatic reg_write(input logic idx, input logic [31:0] val);
    @(negedge clk_i);
    psel = 1'b1; pwrite = 1'b1; penable = 1'b0; paddr = {idx, 2'b00}; pwdata = val;
    @(negedge clk_i);
    penable = 1'b1;
    @(negedge clk_i);
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
  endtask

  task automatic send_beat(input logic [1:0] kind, input logic [15:0] bp,
                           input logic [31:0] chunk);
    @(negedge clk_i);
    if ($urandom_range(99) < snd_idle_pct) begin
      in_if.valid = 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk_i);
    end
    in_if.valid = 1'b1;
    in_if.req_type = kind;
    in_if.base_prime = bp;
    in_if.chunk_index = chunk;
    do @(posedge clk_i); while (!in_if.ready);
  endtask

  task automatic drain();
    @(negedge clk_i);
    in_if.valid = 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
  endtask

  task automatic load_table(input int k);
    send_beat(REQ_CLEAR, 16'($urandom), $urandom);
    for (int i = 0; i < k; i++) send_beat(REQ_APPEND, 16'(seed_primes[i]), $urandom);
  endtask

  task automatic random_phase(input int n_sieves);
    logic [31:0] lim;
    logic [8:0]  clen;
    int unsigned top_chunk;
    int          pick;
    pick = $urandom_range(99);
    if (pick < 55) lim = $urandom_range(100, 20000);
    else if (pick < 75) lim = 32'hFFFF_FFFF;
    else if (pick < 90) lim = $urandom_range(1, 50);
    else lim = $urandom;
    pick = $urandom_range(99);
    if (pick < 70) clen = $urandom_range(1, 64);
    else if (pick < 78) clen = 9'd0;
    else if (pick < 88) clen = 9'd256;
    else clen = $urandom_range(1, 511);
    reg_write(REG_LIMIT, lim);
    reg_write(REG_CLEN, 32'(clen));
    load_table($urandom_range(0, 12));
    top_chunk = (clen == 0) ? 4 : lim / clen;
    for (int s = 0; s < n_sieves; s++) begin
      pick = $urandom_range(99);
      if (pick < 8) begin
        send_beat(REQ_BOGUS, 16'($urandom), $urandom);
      end else if (pick < 14) begin
        send_beat(REQ_APPEND, 16'($urandom), $urandom);
      end else if (pick < 18) begin
        load_table($urandom_range(0, 12));
      end else if (pick < 26 || top_chunk > 32'h7FFF_FFFF) begin
        send_beat(REQ_SIEVE, 16'($urandom), $urandom);
      end else begin
        send_beat(REQ_SIEVE, 16'($urandom),
                  (top_chunk > 1000 && $urandom_range(1)) ?
                  top_chunk - $urandom_range(0, 3) : $urandom_range(0, top_chunk + 1));
      end
    end
    drain();
  endtask

  initial begin
    bit composite;
    in_if.valid = 1'b0;
    in_if.req_type = REQ_CLEAR;
    in_if.base_prime = '0;
    in_if.chunk_index = '0;
    for (int unsigned v = 2; seed_primes.size() < 64; v++) begin
      composite = 1'b0;
      foreach (seed_primes[i]) if (v % seed_primes[i] == 0) composite = 1'b1;
      if (!composite) seed_primes.push_back(v);
    end
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    reg_write(REG_LIMIT, 32'd1000);
    reg_write(REG_CLEN, 32'd150);
    send_beat(REQ_CLEAR, 16'hFFFF, 32'hFFFF_FFFF);
    send_beat(REQ_APPEND, 16'd0, 32'd0);
    send_beat(REQ_APPEND, 16'd1, 32'd0);
    for (int i = 0; i < 5; i++) send_beat(REQ_APPEND, 16'(seed_primes[i]), 32'd0);
    send_beat(REQ_BOGUS, 16'hFFFF, 32'hFFFF_FFFF);
    send_beat(REQ_SIEVE, 16'd0, 32'd0);
    send_beat(REQ_SIEVE, 16'd0, 32'd6);
    send_beat(REQ_SIEVE, 16'd0, 32'd7);
    drain();
    reg_write(REG_CLEN, 32'd0);
    send_beat(REQ_SIEVE, 16'd0, 32'd0);
    drain();
    reg_write(REG_CLEN, 32'd511);
    send_beat(REQ_SIEVE, 16'd0, 32'd1);
    send_beat(REQ_CLEAR, 16'd0, 32'd0);
    send_beat(REQ_SIEVE, 16'd0, 32'd0);
    drain();
    reg_write(REG_LIMIT, 32'hFFFF_FFFF);
    reg_write(REG_CLEN, 32'd256);
    load_table(64);
    send_beat(REQ_SIEVE, 16'd0, 32'h00FF_FFFF);
    send_beat(REQ_SIEVE, 16'd0, 32'hFFFF_FFFF);
    send_beat(REQ_CLEAR, 16'd0, 32'd0);
    send_beat(REQ_APPEND, 16'd7, 32'd0);
    send_beat(REQ_APPEND, 16'd3, 32'd0);
    send_beat(REQ_APPEND, 16'd2, 32'd0);
    send_beat(REQ_SIEVE, 16'd0, 32'd0);
    drain();

    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: begin snd_idle_pct = 0;  rcv_stall_pct = 0;  end
        1: begin snd_idle_pct = 72; rcv_stall_pct = 0;  end
        2: begin snd_idle_pct = 0;  rcv_stall_pct = 72; end
        default: begin snd_idle_pct = 16; rcv_stall_pct = 16; end
      endcase
      if (ph == 4) begin
        reg_write(REG_LIMIT, 32'd5000);
        reg_write(REG_CLEN, 32'd64);
        load_table(10);
        hold_cycles = 3000;
        repeat (6) send_beat(REQ_SIEVE, 16'd0, $urandom_range(0, 70));
        drain();
      end
      random_phase(6);
    end

    if (fail_count == 0) begin
      $display("PASS segmented_prime_sieve");
    end else begin
      $display("FAIL segmented_prime_sieve");
    end
    $finish;
  end
endmodule
